### src/mwls_pkg.sv
// ---------------------------------------------------------------------------
// mwls_pkg
// Shared types and constants for the shortest-window-reaching-sum block.
// ---------------------------------------------------------------------------
`default_nettype none

package mwls_pkg;

  // sequence and datapath sizes
  localparam int MAX_LEN   = 1024;
  localparam int PTR_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int VALUE_W   = 16;
  localparam int TARGET_W  = 26;
  // window sum stays below target before an add, so one extra bit covers it
  localparam int SUM_W     = TARGET_W + 1;

  // queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // stream and register port sizes
  localparam int S_DATA_W  = 16;
  localparam int M_DATA_W  = 16;
  localparam int ADDR_W    = 3;
  localparam int PDATA_W   = 32;

  // register indexes (word address)
  localparam logic REG_TARGET_SUM = 1'b0;

  // one classified item handed from front to back
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               keep;   // within the length limit
  } item_t;

  // sequencer states of the back end
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POP,
    ST_EMIT
  } back_state_t;

  // ring pointer advance with wrap
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(MAX_LEN - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/min_window_length_reaching_sum.sv
// A last item is offered as a result once the engine has checked its window, read and
// dropped each oldest value while the target is reached, and loaded the result
// register; a last item past the length limit goes straight to the result. The engine
// takes no new item until it is back in idle, and each drop waits for the ring read.
// Reset: synchronous; target_sum returns to 1, no ring clearing pass is run.
// ---------------------------------------------------------------------------
// min_window_length_reaching_sum
// Shortest contiguous window whose sum reaches a programmable target,
// reported once per sequence.
// ---------------------------------------------------------------------------
`default_nettype none

module min_window_length_reaching_sum
  import mwls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  // input stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [15:0] value
  input  wire logic                s_tlast,   // last_item
  // result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata    // [10:0] min_length, [11] overflow
);

  logic [TARGET_W-1:0] target_sum;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  item_t               push_item;
  item_t               q_head;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= TARGET_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == REG_TARGET_SUM)) begin
      target_sum <= pwdata[TARGET_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TARGET_SUM) begin
      prdata = {{(PDATA_W - TARGET_W){1'b0}}, target_sum};
    end
  end

  // front: accept and classify
  mwls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // decoupling queue
  mwls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back: window engine and result register
  mwls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .target_sum (target_sum),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

### src/mwls_front.sv
// ---------------------------------------------------------------------------
// mwls_front
// Accepts input transactions, tracks the item count of the current
// sequence and marks items beyond the length limit before queueing them.
// ---------------------------------------------------------------------------
`default_nettype none

module mwls_front
  import mwls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [15:0] value
  input  wire logic                s_tlast,   // last_item
  input  wire logic                q_full,
  output logic                     q_push,
  output item_t                    q_item
);

  logic [CNT_W-1:0] items_seen;
  logic             accept;
  logic             keep;

  // classify the incoming item
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign keep     = (items_seen < CNT_W'(MAX_LEN));

  assign q_push        = accept;
  assign q_item.value  = s_tdata[VALUE_W-1:0];
  assign q_item.last   = s_tlast;
  assign q_item.keep   = keep;

  // per-sequence item counter, cleared by the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      items_seen <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        items_seen <= '0;
      end else if (keep) begin
        items_seen <= items_seen + CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/mwls_queue.sv
// ---------------------------------------------------------------------------
// mwls_queue
// Short first-in first-out queue of classified items between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module mwls_queue
  import mwls_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output item_t      head
);

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/mwls_back.sv
// ---------------------------------------------------------------------------
// mwls_back
// Sliding window engine: appends each value within the length limit to
// the ring memory, pops the oldest values while the window sum reaches
// the target and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mwls_back
  import mwls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [TARGET_W-1:0] target_sum,
  input  wire logic                q_empty,
  input  wire item_t               q_head,
  output logic                     q_pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata   // [10:0] min_length, [11] overflow
);

  // ring memory
  logic [VALUE_W-1:0] ring [MAX_LEN];
  logic [VALUE_W-1:0] rd_data;
  logic               wr_en;
  logic               rd_en;

  // sequence state
  back_state_t      state, state_next;
  logic [PTR_W-1:0] oldest_ptr, oldest_ptr_next;
  logic [PTR_W-1:0] newest_ptr, newest_ptr_next;
  logic [SUM_W-1:0] window_total, window_total_next;
  logic [CNT_W-1:0] window_count, window_count_next;
  logic [CNT_W-1:0] best_length, best_length_next;
  logic             overflow_seen, overflow_seen_next;
  logic             cur_last, cur_last_next;

  // result register
  logic             out_valid, out_valid_next;
  logic [CNT_W-1:0] out_len, out_len_next;
  logic             out_ovf, out_ovf_next;

  logic             reached;

  assign reached = (window_count != '0) && (window_total >= {1'b0, target_sum});

  // memory write of the new value, registered read of the oldest
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[newest_ptr] <= q_head.value;
    end
    if (rd_en) begin
      rd_data <= ring[oldest_ptr];
    end
  end

  // next state and datapath control
  always_comb begin
    state_next         = state;
    oldest_ptr_next    = oldest_ptr;
    newest_ptr_next    = newest_ptr;
    window_total_next  = window_total;
    window_count_next  = window_count;
    best_length_next   = best_length;
    overflow_seen_next = overflow_seen;
    cur_last_next      = cur_last;
    out_valid_next     = out_valid && !m_tready;
    out_len_next       = out_len;
    out_ovf_next       = out_ovf;
    q_pop              = 1'b0;
    wr_en              = 1'b0;
    rd_en              = 1'b0;

    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          cur_last_next = q_head.last;
          if (q_head.keep) begin
            // append the value to the window
            wr_en             = 1'b1;
            newest_ptr_next   = ring_next(newest_ptr);
            window_count_next = window_count + CNT_W'(1);
            window_total_next = window_total + SUM_W'(q_head.value);
            state_next        = ST_CHECK;
          end else begin
            overflow_seen_next = 1'b1;
            state_next         = q_head.last ? ST_EMIT : ST_IDLE;
          end
        end
      end

      ST_CHECK: begin
        if (reached) begin
          // record length, fetch the oldest value for removal
          if ((best_length == '0) || (window_count < best_length)) begin
            best_length_next = window_count;
          end
          rd_en      = 1'b1;
          state_next = ST_POP;
        end else begin
          state_next = cur_last ? ST_EMIT : ST_IDLE;
        end
      end

      ST_POP: begin
        window_total_next = window_total - SUM_W'(rd_data);
        oldest_ptr_next   = ring_next(oldest_ptr);
        window_count_next = window_count - CNT_W'(1);
        state_next        = ST_CHECK;
      end

      ST_EMIT: begin
        if (!out_valid || m_tready) begin
          // load the result and clear the sequence
          out_valid_next     = 1'b1;
          out_len_next       = best_length;
          out_ovf_next       = overflow_seen;
          oldest_ptr_next    = '0;
          newest_ptr_next    = '0;
          window_total_next  = '0;
          window_count_next  = '0;
          best_length_next   = '0;
          overflow_seen_next = 1'b0;
          state_next         = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      oldest_ptr    <= '0;
      newest_ptr    <= '0;
      window_total  <= '0;
      window_count  <= '0;
      best_length   <= '0;
      overflow_seen <= 1'b0;
      cur_last      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      oldest_ptr    <= oldest_ptr_next;
      newest_ptr    <= newest_ptr_next;
      window_total  <= window_total_next;
      window_count  <= window_count_next;
      best_length   <= best_length_next;
      overflow_seen <= overflow_seen_next;
      cur_last      <= cur_last_next;
      out_valid     <= out_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_len <= out_len_next;
    out_ovf <= out_ovf_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - CNT_W - 1){1'b0}}, out_ovf, out_len};

endmodule

`default_nettype wire

### src/mwls_checker.sv
// ---------------------------------------------------------------------------
// mwls_checker
// Port-level checks for the shortest-window block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mwls_checker
  import mwls_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                psel,
  input wire logic                pwrite,
  input wire logic [ADDR_W-1:0]   paddr,
  input wire logic [PDATA_W-1:0]  prdata,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  // a result waiting for the sink stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // reported length never exceeds the sequence limit
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[CNT_W-1:0] <= CNT_W'(MAX_LEN)))
    else $error("min_length beyond sequence limit");

  // target reads back its reset value just after reset
  assert property (@(posedge clk)
    $past(rst) && !rst && psel && !pwrite && (paddr[2] == REG_TARGET_SUM)
      |-> (prdata == PDATA_W'(1)))
    else $error("target_sum reset value wrong");

endmodule

bind min_window_length_reaching_sum mwls_checker u_mwls_checker (
  .clk      (clk),
  .rst      (rst),
  .psel     (psel),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .prdata   (prdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

### sim/window_sum_checker.sv
// ---------------------------------------------------------------------------
// window_sum_checker
// Watches the register port and both streams of the shortest-window block,
// keeps its own sliding window per sequence and compares every result
// transaction against the oldest predicted one. Also checks register reads.
// ---------------------------------------------------------------------------

module window_sum_checker
  import mwls_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic [PDATA_W-1:0]  prdata,
  input  logic                pready,
  // input stream
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] value
  input  logic                s_tlast,   // last_item
  // result stream
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,   // [10:0] min_length, [11] overflow
  // status toward the test top
  output int                  fail_count,
  output int                  results_owed
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] TARGET_ADDR = {REG_TARGET_SUM, 2'b00};

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic             ovf;
  } window_result_t;

  // predicted sequence state
  logic [VALUE_W-1:0]  ring [MAX_LEN];
  logic [PTR_W-1:0]    head;
  logic [PTR_W-1:0]    tail;
  logic [SUM_W-1:0]    run_sum;
  logic [CNT_W-1:0]    span;
  logic [CNT_W-1:0]    shortest;
  logic [CNT_W-1:0]    taken;
  logic                saw_overflow;
  logic [TARGET_W-1:0] goal;

  window_result_t pending_results[$];
  window_result_t want;
  int             mismatches = 0;

  task automatic clear_run();
    head         = '0;
    tail         = '0;
    run_sum      = '0;
    span         = '0;
    shortest     = '0;
    taken        = '0;
    saw_overflow = 1'b0;
  endtask

  // append one value, shrink while the window still reaches the goal
  task automatic slide_window(input logic [VALUE_W-1:0] v, input logic lst);
    window_result_t r;
    if (taken < CNT_W'(MAX_LEN)) begin
      taken      = taken + CNT_W'(1);
      ring[tail] = v;
      tail       = tail + PTR_W'(1);
      span       = span + CNT_W'(1);
      run_sum    = run_sum + SUM_W'(v);
      while (span != '0 && run_sum >= SUM_W'(goal)) begin
        if (shortest == '0 || span < shortest) begin
          shortest = span;
        end
        run_sum = run_sum - SUM_W'(ring[head]);
        head    = head + PTR_W'(1);
        span    = span - CNT_W'(1);
      end
    end else begin
      // beyond the length limit the value is dropped
      saw_overflow = 1'b1;
    end
    if (lst) begin
      r.len = shortest;
      r.ovf = saw_overflow;
      pending_results.push_back(r);
      clear_run();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      goal = TARGET_W'(1);
      clear_run();
      pending_results.delete();
    end else begin
      // register transactions
      if (psel && penable && pready && paddr == TARGET_ADDR) begin
        if (pwrite) begin
          goal = pwdata[TARGET_W-1:0];
        end else if (prdata !== PDATA_W'(goal)) begin
          $error("target_sum mismatch: expected %0d, actual %0d", goal, prdata);
          mismatches++;
        end
      end
      // result transactions
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: min_length %0d, overflow %0b",
                 m_tdata[CNT_W-1:0], m_tdata[CNT_W]);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[CNT_W-1:0] !== want.len) begin
            $error("min_length mismatch: expected %0d, actual %0d",
                   want.len, m_tdata[CNT_W-1:0]);
            mismatches++;
          end
          if (m_tdata[CNT_W] !== want.ovf) begin
            $error("overflow mismatch: expected %0b, actual %0b",
                   want.ovf, m_tdata[CNT_W]);
            mismatches++;
          end
          if (m_tdata[M_DATA_W-1:CNT_W+1] !== '0) begin
            $error("padding mismatch: expected 0, actual %0h",
                   m_tdata[M_DATA_W-1:CNT_W+1]);
            mismatches++;
          end
        end
      end
      // input transactions
      if (s_tvalid && s_tready) begin
        slide_window(s_tdata[VALUE_W-1:0], s_tlast);
      end
    end
    fail_count   <= mismatches;
    results_owed <= pending_results.size();
  end

endmodule

### sim/min_window_length_reaching_sum_test.sv
// ---------------------------------------------------------------------------
// min_window_length_reaching_sum_test
// Drives sequences of values into the shortest-window block under a range
// of targets, with random gaps and result back-pressure, and leaves all
// prediction and comparison to the checker instantiated beside the block.
// ---------------------------------------------------------------------------

module min_window_length_reaching_sum_test
  import mwls_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0]   TARGET_ADDR  = {REG_TARGET_SUM, 2'b00};
  localparam logic [TARGET_W-1:0] TARGET_MAX   = '1;
  // worst case for the engine to empty a full window plus queued items
  localparam int                  ENGINE_DRAIN = 2 * MAX_LEN + 64;
  localparam int                  TAIL_CYCLES  = 100;
  localparam int                  STALL_LIMIT  = 20000;
  localparam int                  SHORT_ITEMS  = 200;

  typedef enum int {
    MIX_FULL,
    MIX_SMALL,
    MIX_SPARSE
  } value_mix_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ADDR_W-1:0]   paddr    = '0;
  logic [PDATA_W-1:0]  pwdata   = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;   // [15:0] value
  logic                s_tlast  = 1'b0; // last_item
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;         // [10:0] min_length, [11] overflow

  int   fail_count;
  int   results_owed;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   stall_left = 0;
  int   rx_roll;
  int   idle_cycles = 0;

  min_window_length_reaching_sum DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  window_sum_checker u_window_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_steady) begin
      m_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        m_tready <= 1'b1;
      end else if (rx_roll < 94) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(10, 70);
      end
    end
  end

  // watchdog on cycles without any stream transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap(input logic steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 75) begin
      return 0;
    end
    if (r < 96) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(input value_mix_t mix);
    logic [VALUE_W-1:0] v;
    case (mix)
      MIX_SMALL: begin
        v = VALUE_W'($urandom_range(0, 15));
      end
      MIX_SPARSE: begin
        v = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom) : '0;
      end
      default: begin
        v = VALUE_W'($urandom);
      end
    endcase
    return v;
  endfunction

  // targets mostly scaled so that windows of a few values reach them
  function automatic logic [TARGET_W-1:0] pick_goal(input value_mix_t mix);
    logic [TARGET_W-1:0] g;
    case ($urandom_range(0, 9))
      0: g = '0;
      1: g = TARGET_MAX;
      2: g = TARGET_W'($urandom);
      default: begin
        case (mix)
          MIX_SMALL:  g = TARGET_W'($urandom_range(1, 120));
          MIX_SPARSE: g = TARGET_W'($urandom_range(1, 200000));
          default:    g = TARGET_W'($urandom_range(1, 65535 * $urandom_range(1, 10)));
        endcase
      end
    endcase
    return g;
  endfunction

  // one input transaction; valid stays high when the next follows at once
  task automatic send_item(input logic [VALUE_W-1:0] v, input logic lst);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'(v);
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_results();
    do @(posedge clk); while (results_owed != 0);
  endtask

  // stop the stream and let the engine finish any window shrinking
  task automatic settle_engine();
    s_tvalid <= 1'b0;
    wait_results();
    repeat (ENGINE_DRAIN) @(posedge clk);
  endtask

  // write the target, then read it back in the next transfer
  task automatic program_target(input logic [TARGET_W-1:0] goal);
    logic [PDATA_W-1:0] word;
    word                = $urandom;
    word[TARGET_W-1:0]  = goal;
    settle_engine();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TARGET_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_sequence(input int len, input value_mix_t mix, input int retarget_at);
    for (int i = 0; i < len; i++) begin
      if (i == retarget_at) begin
        program_target(pick_goal(mix));
      end
      send_item(pick_value(mix), i == len - 1);
    end
  endtask

  initial begin
    value_mix_t mix;
    int         short_sent;
    int         len;
    int         split;
    int         phase;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset target of one: zero never reaches it, a full value does
    send_item(16'h0000, 1'b1);
    send_item(16'hFFFF, 1'b1);
    // zero target: every window reaches it
    program_target('0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0000, 1'b1);
    // small target reached by the whole run, then by one value
    program_target(TARGET_W'(3));
    send_item(16'h0001, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h0001, 1'b1);
    send_item(16'h0003, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h0001, 1'b1);
    // largest target cannot be reached
    program_target(TARGET_MAX);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b1);
    // sum just past two full values
    program_target(TARGET_W'(32'h0002_0000));
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b1);
    // target lowered in the middle of a sequence
    program_target(TARGET_W'(10));
    send_item(16'h0004, 1'b0);
    send_item(16'h0004, 1'b0);
    program_target(TARGET_W'(8));
    send_item(16'h0000, 1'b1);

    // random phases, each with its own target, value mix and idling
    short_sent = 0;
    phase      = 0;
    while (short_sent < SHORT_ITEMS || phase < 2) begin
      mix       = value_mix_t'($urandom_range(0, 2));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady <= ($urandom_range(0, 3) == 0);
      program_target(pick_goal(mix));

      for (int s = 0; s < 12; s++) begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        split = ($urandom_range(0, 11) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
        send_sequence(len, mix, split);
        short_sent += len;
        if ($urandom_range(0, 19) == 0) begin
          s_tvalid <= 1'b0;
          wait_results();
        end
      end

      // full ring with wrap, then a run past the length limit
      if (phase == 0 || phase == 1) begin
        tx_steady = 1'b1;
        program_target(TARGET_W'($urandom_range(1 << 22, 1 << 25)));
        len = (phase == 0) ? MAX_LEN : MAX_LEN + 1 + $urandom_range(0, 20);
        send_sequence(len, MIX_FULL, -1);
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
